// ----- rtl/bhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bhq_pkg: shared types and constants of the max priority queue
// Data widths, operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam int DataW   = 32;
  localparam int OccW    = 8;
  localparam int StatusW = 2;

  typedef enum logic {
    ModeInsert = 1'b0,
    ModeDelete = 1'b1
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // Broadcast to every cell of the chain for one transaction.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctl_t;

endpackage

// ----- rtl/bhq_cell.sv -----
// ----------------------------------------------------------------------------
// bhq_cell: one slot of the sorted queue chain
// Holds one value; on insert it keeps, takes the new value or takes its upper
// neighbor's value; on delete it takes its lower neighbor's value.
// ----------------------------------------------------------------------------
module bhq_cell (
  input  logic                                clk_i,
  input  bhq_pkg::cell_ctl_t                  ctl_i,
  input  logic signed [bhq_pkg::DataW-1:0]    item_i,
  input  logic signed [bhq_pkg::DataW-1:0]    prev_value_i,
  input  logic signed [bhq_pkg::DataW-1:0]    next_value_i,
  input  logic                                prev_ge_i,
  input  logic                                prev_occ_i,
  input  logic                                occ_i,
  output logic signed [bhq_pkg::DataW-1:0]    value_o,
  output logic                                ge_o
);
  import bhq_pkg::*;

  logic signed [DataW-1:0] value_d, value_q;

  // This slot is occupied and already at least as large as the new value.
  assign ge_o    = occ_i && (value_q >= item_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctl_i.insert && prev_occ_i) begin
      if (ge_o) begin
        value_d = value_q;
      end else if (prev_ge_i) begin
        value_d = item_i;
      end else begin
        value_d = prev_value_i;
      end
    end else if (ctl_i.remove && occ_i) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ----- rtl/binary_max_heap_queue.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_queue: max priority queue of signed 32-bit values
// Result: the strobe done_o rises in the cycle after start is taken.
// Throughput: one transaction per cycle; busy is never raised, and the
// receiver cannot stall the result, which is shown for exactly one cycle.
// Reset clears the entry count and the strobe at once; no clearing pass runs,
// slot contents are left undefined and are never read before being written.
// ----------------------------------------------------------------------------
module binary_max_heap_queue #(
  parameter int CAPACITY = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode_i,
  input  logic signed [bhq_pkg::DataW-1:0]  item_value_i,
  output logic                              done_o,
  output logic signed [bhq_pkg::DataW-1:0]  removed_value_o,
  output logic [bhq_pkg::StatusW-1:0]       status_o,
  output logic [bhq_pkg::OccW-1:0]          occupancy_o
);
  import bhq_pkg::*;

  // The queue is kept as a chain of cells sorted from largest (cell 0) to
  // smallest. An insert is resolved in all cells in parallel: every occupied cell that
  // already holds a value at least as large keeps it, the first cell below
  // them takes the new value, and every cell further down takes its upper
  // neighbor's value, so the tail shifts down by one slot. A delete returns
  // cell 0 and shifts the whole chain up by one slot. The maximum, the count
  // and the status match those of a binary heap exactly, since a priority
  // queue's observable answers do not depend on how it lays out its entries.

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]         count_d, count_q;
  logic                    accept;
  logic                    is_full, is_empty;
  logic                    do_insert, do_delete;
  cell_ctl_t               cell_ctl;

  logic signed [DataW-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]     cell_ge;
  logic [CAPACITY-1:0]     cell_occ;

  logic                    done_q;
  logic signed [DataW-1:0] removed_d, removed_q;
  status_e                 status_d, status_q;
  logic [CntW+OccW-1:0]    occ_wide;

  // Every transaction finishes in the cycle it is taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full   = (count_q == CntW'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign do_insert = accept && (mode_e'(mode_i) == ModeInsert) && !is_full;
  assign do_delete = accept && (mode_e'(mode_i) == ModeDelete) && !is_empty;

  assign cell_ctl.insert = do_insert;
  assign cell_ctl.remove = do_delete;

  // Refused operations leave count and cells untouched and report zero.
  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    status_d  = StOk;
    if (accept) begin
      if (mode_e'(mode_i) == ModeInsert) begin
        if (is_full) begin
          status_d = StFull;
        end else begin
          count_d = count_q + 1'b1;
        end
      end else begin
        if (is_empty) begin
          status_d = StEmpty;
        end else begin
          removed_d = cell_value[0];
          count_d   = count_q - 1'b1;
        end
      end
    end
  end

  // The chain of cells. Slot i is occupied when i is below the entry count.
  // Cell 0 sees an imaginary upper neighbor that is occupied and larger than
  // anything, and the last cell refills from itself on a delete.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] prev_value;
    logic signed [DataW-1:0] next_value;
    logic                    prev_ge;
    logic                    prev_occ;

    assign cell_occ[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign prev_value = item_value_i;
      assign prev_ge    = 1'b1;
      assign prev_occ   = 1'b1;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_ge    = cell_ge[i-1];
      assign prev_occ   = cell_occ[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = cell_value[i];
    end else begin : g_link
      assign next_value = cell_value[i+1];
    end

    bhq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl),
      .item_i       (item_value_i),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .prev_ge_i    (prev_ge),
      .prev_occ_i   (prev_occ),
      .occ_i        (cell_occ[i]),
      .value_o      (cell_value[i]),
      .ge_o         (cell_ge[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed_d;
      status_q  <= status_d;
    end
  end

  // The occupancy port carries the low bits of the count.
  assign occ_wide = {{OccW{1'b0}}, count_q};

  assign done_o          = done_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign occupancy_o     = occ_wide[OccW-1:0];

endmodule

// ----- rtl/bhq_checker.sv -----
// ----------------------------------------------------------------------------
// bhq_checker: port-level checks of the max priority queue
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module bhq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic signed [bhq_pkg::DataW-1:0]  removed_value_o,
  input logic [bhq_pkg::StatusW-1:0]       status_o,
  input logic [bhq_pkg::OccW-1:0]          occupancy_o
);
  import bhq_pkg::*;

  // Each taken transaction produces its result in the following cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("taken transaction gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without a taken transaction");

  // Refused operations report no value.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != StOk)) |-> (removed_value_o == '0))
    else $error("refused operation returned a value");

  // An empty refusal can only happen with nothing held.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == StEmpty)) |-> (occupancy_o == '0))
    else $error("empty status with entries held");

endmodule

bind binary_max_heap_queue bhq_checker u_bhq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .removed_value_o (removed_value_o),
  .status_o        (status_o),
  .occupancy_o     (occupancy_o)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for binary_max_heap_queue
// Inserts and delete-max transactions go to the queue in bursts with random
// gaps. A shadow heap in the bench predicts each result, and every result
// strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import bhq_pkg::*;

  localparam int ClkPeriod    = 4;
  localparam int ResetCycles  = 6;
  localparam int Capacity     = 128;
  localparam int NumOps       = 1100;
  // The strobe comes in the cycle after an accepted transaction; the settle
  // time after the last result lets any stray strobe show up.
  localparam int SettleCycles = 8;
  // Slowest correct run: about 1100 transactions, with a random idle gap after
  // most bursts, plus reset. The limit is many times that.
  localparam int CycleLimit   = 200000;

  typedef struct {
    mode_e                    mode;
    logic signed [DataW-1:0]  value;
  } heap_op_t;

  typedef struct {
    logic signed [DataW-1:0]  removed;
    status_e                  status;
    logic [OccW-1:0]          occupancy;
  } heap_outcome_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     start        = 1'b0;
  logic                     mode_i       = 1'b0;
  logic signed [DataW-1:0]  item_value_i = '0;
  logic                     busy;
  logic                     done_o;
  logic signed [DataW-1:0]  removed_value_o;
  logic [StatusW-1:0]       status_o;
  logic [OccW-1:0]          occupancy_o;

  binary_max_heap_queue #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .item_value_i   (item_value_i),
    .done_o         (done_o),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Transactions waiting to be driven, and results predicted but not yet seen.
  heap_op_t       queued_ops[$];
  heap_outcome_t  awaited_outcomes[$];

  // Shadow copy of the heap. Only slots below shadow_size are ever read, so
  // the undefined contents of unwritten slots never matter.
  logic signed [DataW-1:0]  shadow_slots [Capacity];
  int unsigned              shadow_size = 0;

  int unsigned  fail_count  = 0;
  int unsigned  cycle_count = 0;

  // Applies one transaction to the shadow heap and returns the result the
  // queue must report for it. Compares are signed and strict, so equal
  // values never swap; on the way down the left child wins a tie.
  function automatic heap_outcome_t shadow_heap_apply(heap_op_t op);
    heap_outcome_t            res;
    int unsigned              pos;
    int unsigned              parent;
    int unsigned              best;
    int unsigned              lchild;
    int unsigned              rchild;
    logic signed [DataW-1:0]  tmp;
    res.removed = '0;
    res.status  = StOk;
    if (op.mode == ModeInsert) begin
      if (shadow_size >= Capacity) begin
        res.status = StFull;
      end else begin
        pos = shadow_size;
        shadow_slots[pos] = op.value;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!(shadow_slots[pos] > shadow_slots[parent])) break;
          tmp = shadow_slots[pos];
          shadow_slots[pos] = shadow_slots[parent];
          shadow_slots[parent] = tmp;
          pos = parent;
        end
        shadow_size++;
      end
    end else begin
      if (shadow_size == 0) begin
        res.status = StEmpty;
      end else begin
        res.removed = shadow_slots[0];
        shadow_slots[0] = shadow_slots[shadow_size - 1];
        shadow_size--;
        pos = 0;
        while (1) begin
          best   = pos;
          lchild = 2 * pos + 1;
          rchild = 2 * pos + 2;
          if (lchild < shadow_size && shadow_slots[lchild] > shadow_slots[best]) best = lchild;
          if (rchild < shadow_size && shadow_slots[rchild] > shadow_slots[best]) best = rchild;
          if (best == pos) break;
          tmp = shadow_slots[pos];
          shadow_slots[pos] = shadow_slots[best];
          shadow_slots[best] = tmp;
          pos = best;
        end
      end
    end
    res.occupancy = OccW'(shadow_size);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation. The generator keeps its own count of held entries so
  // that fill and drain phases can run exactly past the full and empty marks.
  // ---------------------------------------------------------------------------
  int unsigned  gen_ops   = 0;
  int unsigned  gen_count = 0;

  task automatic push_op(mode_e mode, logic signed [DataW-1:0] value);
    heap_op_t op;
    op.mode  = mode;
    op.value = value;
    queued_ops.push_back(op);
    gen_ops++;
    if (mode == ModeInsert && gen_count < Capacity) gen_count++;
    if (mode == ModeDelete && gen_count > 0) gen_count--;
  endtask

  // Mixes extremes, a narrow band around zero that makes ties frequent, and
  // full-range values that exercise every bit.
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(DataW - 1){1'b1}}};
      1: return {1'b1, {(DataW - 1){1'b0}}};
      2, 3: return DataW'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  localparam logic signed [DataW-1:0] MaxVal = {1'b0, {(DataW - 1){1'b1}}};
  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW - 1){1'b0}}};

  initial begin
    int unsigned  phase_len;
    int unsigned  insert_pct;
    int unsigned  kind;
    bit           first_phase;

    // Directed part: delete from an empty queue, both extremes, ties at the
    // top and the bottom, a drain one past empty, then three equal values and a delete.
    push_op(ModeDelete, MaxVal);
    push_op(ModeDelete, 32'sd0);
    push_op(ModeInsert, 32'sd0);
    push_op(ModeInsert, MaxVal);
    push_op(ModeInsert, MinVal);
    push_op(ModeInsert, -32'sd1);
    push_op(ModeInsert, 32'sd5);
    push_op(ModeInsert, 32'sd5);
    push_op(ModeInsert, MinVal);
    push_op(ModeInsert, MaxVal);
    push_op(ModeInsert, 32'sd1);
    repeat (10) push_op(ModeDelete, $urandom());
    push_op(ModeInsert, 32'sd7);
    push_op(ModeInsert, 32'sd7);
    push_op(ModeInsert, 32'sd7);
    push_op(ModeDelete, MinVal);

    // Random part. The first phase always fills past full so the refusal on a
    // full heap is certain to be reached.
    first_phase = 1'b1;
    while (gen_ops < NumOps) begin
      kind = first_phase ? 7 : $urandom_range(0, 9);
      first_phase = 1'b0;
      if (kind <= 6) begin
        phase_len  = $urandom_range(10, 60);
        insert_pct = $urandom_range(30, 75);
        repeat (phase_len) begin
          if ($urandom_range(0, 99) < insert_pct) push_op(ModeInsert, pick_value());
          else push_op(ModeDelete, $urandom());
        end
      end else if (kind <= 8) begin
        phase_len = Capacity - gen_count + $urandom_range(1, 3);
        repeat (phase_len) push_op(ModeInsert, pick_value());
      end else begin
        phase_len = gen_count + $urandom_range(1, 3);
        repeat (phase_len) push_op(ModeDelete, $urandom());
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until everything has been driven, accepted and answered.
    do @(posedge clk_i);
    while (queued_ops.size() != 0 || start || awaited_outcomes.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);

    if (fail_count == 0 && awaited_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver. A transaction is taken at an edge where start is high and busy is
  // low; the prediction is made right there. The sender alternates bursts of
  // random length with random gaps, and some gaps are zero so that long
  // back-to-back stretches occur too. start gets exactly one assignment per
  // edge, so it stays high across back-to-back transactions.
  // ---------------------------------------------------------------------------
  heap_op_t     current_op;
  int unsigned  burst_left = 0;
  int unsigned  gap_left   = 0;

  always @(posedge clk_i) begin
    heap_op_t next_op;
    logic     taken;
    if (rst_ni) begin
      taken = start && !busy;
      if (taken) awaited_outcomes.push_back(shadow_heap_apply(current_op));
      if (taken || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (queued_ops.size() > 0) begin
          next_op = queued_ops.pop_front();
          current_op = next_op;
          start        <= 1'b1;
          mode_i       <= next_op.mode;
          item_value_i <= next_op.value;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. The receiver cannot stall the queue: a result is there for one
  // cycle only and is taken at the edge that ends it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    heap_outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: result with no transaction pending: removed %0d status %0d occupancy %0d",
                 $time, removed_value_o, status_o, occupancy_o);
        fail_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (removed_value_o !== want.removed) begin
          $display("%0t: removed_value expected %0d actual %0d",
                   $time, want.removed, removed_value_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          fail_count++;
        end
        if (occupancy_o !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d",
                   $time, want.occupancy, occupancy_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog against a hung queue or a lost result.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_outcomes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
rtl/bhq_pkg.sv
rtl/bhq_cell.sv
rtl/binary_max_heap_queue.sv
rtl/bhq_checker.sv
dv/testbench.sv
